// File: design/rmc_sentence_field_extractor_top_macros.svh
// Assertion macros used by the RMC sentence field extractor top level.
`ifndef RMC_SENTENCE_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define RMC_SENTENCE_FIELD_EXTRACTOR_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define RMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rmc_sx_pkg.sv
// Types and character constants for the RMC sentence field extractor.
package rmc_sx_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Body field numbers
  localparam logic [3:0] FLD_TIME   = 4'd0;
  localparam logic [3:0] FLD_STATUS = 4'd1;
  localparam logic [3:0] FLD_LAT    = 4'd2;
  localparam logic [3:0] FLD_NS     = 4'd3;
  localparam logic [3:0] FLD_LON    = 4'd4;
  localparam logic [3:0] FLD_EW     = 4'd5;
  localparam logic [3:0] FLD_DATE   = 4'd8;
  localparam logic [3:0] FLD_LIMIT  = 4'd15;

  localparam logic [3:0] DATE_CAP = 4'd6;

  // Output tdata is 157 bits of fields, padded to whole bytes
  localparam int unsigned RESULT_W = 157;
  localparam int unsigned TDATA_W  = 160;

  typedef struct packed {
    logic [23:0] date_bcd;
    logic [7:0]  lon_hemisphere;
    logic [39:0] lon_bcd;
    logic [7:0]  lat_hemisphere;
    logic [35:0] lat_bcd;
    logic [31:0] time_bcd;
    logic [7:0]  status_char;
    logic        fix_valid;
  } rmc_result_t;

  // Expected character at each header position "$GPRMC,"
  function automatic logic [7:0] hdr_char(input logic [2:0] stage);
    logic [7:0] ch;
    unique case (stage)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = CH_G;
      3'd2:    ch = CH_P;
      3'd3:    ch = CH_R;
      3'd4:    ch = CH_M;
      3'd5:    ch = CH_C;
      3'd6:    ch = CH_COMMA;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// File: design/rmc_sentence_field_extractor_top.sv
// Top level of the RMC sentence field extractor: byte stream in, decoded fix out.
// A byte waits in the input register; parsing a CR loads the result register.
// Throughput: one byte per cycle; a byte that ends a sentence waits only if the
//   result register still holds an untaken result. Other bytes never wait on the sink.
// Reset (rst, synchronous): header matcher idle, captures cleared, no request pending.
`include "rmc_sentence_field_extractor_top_macros.svh"

module rmc_sentence_field_extractor_top #(
  parameter int TIME_DIGITS = 8,   // 6..8 time digits kept
  parameter int LAT_DIGITS  = 9,   // 4..9 latitude digits kept
  parameter int LON_DIGITS  = 10   // 5..10 longitude digits kept
) (
  input  logic         clk,
  input  logic         rst,
  // Byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // Decoded sentences
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] fix_valid, [8:1] status_char, [40:9] time_bcd, [76:41] lat_bcd,
  // [84:77] lat_hemisphere, [124:85] lon_bcd, [132:125] lon_hemisphere,
  // [156:133] date_bcd, [159:157] zero
  output logic [159:0] m_axis_tdata
);

  // Input register: one received byte waiting to be parsed
  logic       in_valid;
  logic [7:0] in_byte;

  logic                    emit;      // parsed byte is the CR closing a sentence
  logic                    out_free;  // result register can take a new request
  logic                    step;      // parse the held byte this cycle
  rmc_sx_pkg::rmc_result_t result;

  // A byte that yields no result never needs the result register.
  assign step          = in_valid && (!emit || out_free);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  rmc_sx_parser #(
    .TIME_DIGITS (TIME_DIGITS),
    .LAT_DIGITS  (LAT_DIGITS),
    .LON_DIGITS  (LON_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .emit    (emit),
    .result  (result)
  );

  rmc_sx_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && emit),
    .result (result),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (m_axis_tdata),
    .free   (out_free)
  );

  // A valid fix always reports status 'A'
  `RMC_ASSERT(a_fix_status, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:1] == rmc_sx_pkg::CH_A, "fix flagged without status A")
  // Without a fix, the latitude, its hemisphere and the date are blanked
  `RMC_ASSERT(a_nofix_blank, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[76:41] == '0 && m_axis_tdata[84:77] == rmc_sx_pkg::CH_ZERO && m_axis_tdata[156:133] == '0, "position not blanked without fix")
  // A held byte that is not parsed stays held
  `RMC_ASSERT(a_in_hold, in_valid && !step |=> in_valid && $stable(in_byte), "pending byte dropped")
  // Result register never overwritten while occupied and stalled
  `RMC_ASSERT(a_no_overrun, m_axis_tvalid && !m_axis_tready |-> !(step && emit), "result overwritten")
  // Reset leaves nothing pending
  `RMC_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_axis_tvalid && !in_valid, "request pending after reset")

endmodule

// File: design/rmc_sx_parser.sv
// Header matcher, field counter and BCD capture registers.
module rmc_sx_parser #(
  parameter int TIME_DIGITS = 8,
  parameter int LAT_DIGITS  = 9,
  parameter int LON_DIGITS  = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               rx_byte,
  output logic                     emit,
  output rmc_sx_pkg::rmc_result_t  result
);

  localparam int TIME_W = 4 * TIME_DIGITS;
  localparam int LAT_W  = 4 * LAT_DIGITS;
  localparam int LON_W  = 4 * LON_DIGITS;
  localparam logic [3:0] TIME_CAP = 4'(TIME_DIGITS);
  localparam logic [3:0] LAT_CAP  = 4'(LAT_DIGITS);
  localparam logic [3:0] LON_CAP  = 4'(LON_DIGITS);

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_LAST = 3'd6;
  localparam logic [2:0] HDR_BODY = 3'd7;

  logic [2:0]        header_stage, header_stage_next;
  logic [3:0]        field_number, field_number_next;
  logic [3:0]        digit_count, digit_count_next;
  logic [TIME_W-1:0] time_digits, time_digits_next;
  logic [7:0]        status_store, status_store_next;
  logic [LAT_W-1:0]  lat_digits, lat_digits_next;
  logic [7:0]        north_south, north_south_next;
  logic [LON_W-1:0]  lon_digits, lon_digits_next;
  logic [7:0]        east_west, east_west_next;
  logic [23:0]       date_digits, date_digits_next;

  logic       is_digit;
  logic       first;
  logic [3:0] digit;
  logic       fix_ok;

  assign is_digit = (rx_byte >= rmc_sx_pkg::CH_ZERO) && (rx_byte <= rmc_sx_pkg::CH_NINE);
  assign first    = (digit_count == 4'd0);
  assign digit    = rx_byte[3:0];

  always_comb begin
    header_stage_next = header_stage;
    field_number_next = field_number;
    digit_count_next  = digit_count;
    time_digits_next  = time_digits;
    status_store_next = status_store;
    lat_digits_next   = lat_digits;
    north_south_next  = north_south;
    lon_digits_next   = lon_digits;
    east_west_next    = east_west;
    date_digits_next  = date_digits;
    emit              = 1'b0;

    if (header_stage != HDR_BODY) begin
      if (rx_byte == rmc_sx_pkg::hdr_char(header_stage)) begin
        header_stage_next = header_stage + 3'd1;
        if (header_stage == HDR_LAST) begin
          field_number_next = '0;
          digit_count_next  = '0;
          time_digits_next  = '0;
          status_store_next = rmc_sx_pkg::CH_ZERO;
          lat_digits_next   = '0;
          north_south_next  = rmc_sx_pkg::CH_ZERO;
          lon_digits_next   = '0;
          east_west_next    = rmc_sx_pkg::CH_ZERO;
          date_digits_next  = '0;
        end
      end else begin
        header_stage_next = HDR_IDLE;
      end
    end else if (rx_byte == rmc_sx_pkg::CH_CR) begin
      emit              = 1'b1;
      header_stage_next = HDR_IDLE;
    end else if (rx_byte == rmc_sx_pkg::CH_COMMA) begin
      if (field_number != rmc_sx_pkg::FLD_LIMIT) begin
        field_number_next = field_number + 4'd1;
      end
      digit_count_next = '0;
    end else begin
      unique case (field_number)
        rmc_sx_pkg::FLD_TIME: begin
          if (is_digit && (digit_count < TIME_CAP)) begin
            time_digits_next = {time_digits[TIME_W-5:0], digit};
            digit_count_next = digit_count + 4'd1;
          end
        end
        rmc_sx_pkg::FLD_LAT: begin
          if (is_digit && (digit_count < LAT_CAP)) begin
            lat_digits_next  = {lat_digits[LAT_W-5:0], digit};
            digit_count_next = digit_count + 4'd1;
          end
        end
        rmc_sx_pkg::FLD_LON: begin
          if (is_digit && (digit_count < LON_CAP)) begin
            lon_digits_next  = {lon_digits[LON_W-5:0], digit};
            digit_count_next = digit_count + 4'd1;
          end
        end
        rmc_sx_pkg::FLD_DATE: begin
          if (is_digit && (digit_count < rmc_sx_pkg::DATE_CAP)) begin
            date_digits_next = {date_digits[19:0], digit};
            digit_count_next = digit_count + 4'd1;
          end
        end
        // single-character fields keep only their first byte
        rmc_sx_pkg::FLD_STATUS: begin
          if (first) begin
            status_store_next = rx_byte;
            digit_count_next  = 4'd1;
          end
        end
        rmc_sx_pkg::FLD_NS: begin
          if (first) begin
            north_south_next = rx_byte;
            digit_count_next = 4'd1;
          end
        end
        rmc_sx_pkg::FLD_EW: begin
          if (first) begin
            east_west_next   = rx_byte;
            digit_count_next = 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_stage <= HDR_IDLE;
      field_number <= '0;
      digit_count  <= '0;
      time_digits  <= '0;
      status_store <= rmc_sx_pkg::CH_ZERO;
      lat_digits   <= '0;
      north_south  <= rmc_sx_pkg::CH_ZERO;
      lon_digits   <= '0;
      east_west    <= rmc_sx_pkg::CH_ZERO;
      date_digits  <= '0;
    end else if (step) begin
      header_stage <= header_stage_next;
      field_number <= field_number_next;
      digit_count  <= digit_count_next;
      time_digits  <= time_digits_next;
      status_store <= status_store_next;
      lat_digits   <= lat_digits_next;
      north_south  <= north_south_next;
      lon_digits   <= lon_digits_next;
      east_west    <= east_west_next;
      date_digits  <= date_digits_next;
    end
  end

  assign fix_ok = (status_store == rmc_sx_pkg::CH_A);

  always_comb begin
    result.fix_valid      = fix_ok;
    result.status_char    = status_store;
    result.time_bcd       = 32'(time_digits);
    result.lat_bcd        = fix_ok ? 36'(lat_digits) : '0;
    result.lat_hemisphere = fix_ok ? north_south : rmc_sx_pkg::CH_ZERO;
    result.lon_bcd        = fix_ok ? 40'(lon_digits) : '0;
    result.lon_hemisphere = fix_ok ? east_west : rmc_sx_pkg::CH_ZERO;
    result.date_bcd       = fix_ok ? date_digits : '0;
  end

endmodule

// File: design/rmc_sx_out_stage.sv
// Result register holding one decoded sentence until the sink takes it.
module rmc_sx_out_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  rmc_sx_pkg::rmc_result_t            result,
  output logic                               tvalid,
  input  logic                               tready,
  output logic [rmc_sx_pkg::TDATA_W-1:0]     tdata,
  output logic                               free
);

  rmc_sx_pkg::rmc_result_t held;

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign tdata = {(rmc_sx_pkg::TDATA_W - rmc_sx_pkg::RESULT_W)'(0), held};

endmodule
